@@ rtl/core/hhq_pkg.sv @@
`timescale 1ns / 1ps

package hhq_pkg;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLUMNS,
    REG_ROWS,
    REG_ORIGIN_X,
    REG_ORIGIN_Z,
    REG_INV_CELL_WIDTH,
    REG_INV_CELL_DEPTH
  } cfg_reg_t;

  // Corner slots, in the order they are read
  typedef enum logic [1:0] {
    CORNER_FAR_LEFT,
    CORNER_FAR_RIGHT,
    CORNER_NEAR_LEFT,
    CORNER_NEAR_RIGHT
  } corner_t;

  // Corner read sequencer
  typedef enum logic [1:0] {
    FETCH_IDLE,
    FETCH_FAR_RIGHT,
    FETCH_NEAR_LEFT,
    FETCH_NEAR_RIGHT
  } fetch_state_t;

  // Input word
  typedef struct packed {
    logic               kind;
    logic [15:0]        vertex_index;
    logic signed [31:0] height_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] height;
    logic               outside;
  } out_word_t;

  // Work handed from the locate pipeline to the height store
  typedef struct packed {
    logic               is_query;
    logic               store;     // write index within the store
    logic               outside;
    logic [15:0]        fx;
    logic [16:0]        fy;        // 1..65536
    logic signed [31:0] wdata;
  } job_t;

  // Four corners plus weights, handed to the blend pipeline
  typedef struct packed {
    logic               outside;
    logic [15:0]        fx;
    logic [16:0]        fy;
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] y3;
  } corner_set_t;

endpackage

@@ rtl/core/heightfield_height_query.sv @@
`timescale 1ns / 1ps
// A query inside the grid and a query outside the interior each give one result
// word; a height write gives no word. A query inside the grid makes four corner
// reads through the single port of the height store, which takes no other job
// meanwhile; height writes one per cycle while the store and the pipeline do not stall.
// Reset (synchronous, rst high): clears pipeline valids and the read sequencer and
// loads the register defaults; the height store is not cleared.

module heightfield_height_query
  import hhq_pkg::*;
#(
  parameter int MAX_VERTICES = 65536,
  parameter int MAX_SIDE     = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > 9) ? SW : 9;

  // Configuration registers
  logic [8:0]         columns;
  logic [8:0]         rows;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_z;
  logic [31:0]        inverse_cell_width;
  logic [31:0]        inverse_cell_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns            <= 9'd2;
      rows               <= 9'd2;
      origin_x           <= 32'sd0;
      origin_z           <= 32'sd0;
      inverse_cell_width <= 32'd65536;
      inverse_cell_depth <= 32'd65536;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLUMNS:        columns            <= cfg_data[8:0];
        REG_ROWS:           rows               <= cfg_data[8:0];
        REG_ORIGIN_X:       origin_x           <= cfg_data;
        REG_ORIGIN_Z:       origin_z           <= cfg_data;
        REG_INV_CELL_WIDTH: inverse_cell_width <= cfg_data;
        REG_INV_CELL_DEPTH: inverse_cell_depth <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Grid size held to 2..MAX_SIDE
  logic [CW-1:0] cols_ext, rows_ext;
  logic [SW-1:0] cols_c, rows_c;

  assign cols_ext = CW'(columns);
  assign rows_ext = CW'(rows);

  always_comb begin
    if (cols_ext < CW'(2))             cols_c = SW'(2);
    else if (cols_ext > CW'(MAX_SIDE)) cols_c = SW'(MAX_SIDE);
    else                               cols_c = SW'(cols_ext);
    if (rows_ext < CW'(2))             rows_c = SW'(2);
    else if (rows_ext > CW'(MAX_SIDE)) rows_c = SW'(MAX_SIDE);
    else                               rows_c = SW'(rows_ext);
  end

  logic          job_valid, job_ready;
  job_t          job;
  logic [AW-1:0] job_addr;

  logic          cor_valid, cor_ready;
  corner_set_t   cor;

  hhq_locate #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .SW           (SW)
  ) u_locate (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_word            (in_word),
    .origin_x           (origin_x),
    .origin_z           (origin_z),
    .inverse_cell_width (inverse_cell_width),
    .inverse_cell_depth (inverse_cell_depth),
    .cols               (cols_c),
    .rows               (rows_c),
    .job_valid          (job_valid),
    .job_ready          (job_ready),
    .job                (job),
    .job_addr           (job_addr)
  );

  hhq_fetch #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .SW           (SW)
  ) u_fetch (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_addr  (job_addr),
    .cols      (cols_c),
    .cor_valid (cor_valid),
    .cor_ready (cor_ready),
    .cor       (cor)
  );

  hhq_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .cor_valid (cor_valid),
    .cor_ready (cor_ready),
    .cor       (cor),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ rtl/core/hhq_locate.sv @@
`timescale 1ns / 1ps

module hhq_locate
  import hhq_pkg::*;
#(
  parameter int MAX_VERTICES = 65536,
  parameter int AW           = 16,
  parameter int SW           = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_word,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_z,
  input  logic [31:0]        inverse_cell_width,
  input  logic [31:0]        inverse_cell_depth,
  input  logic [SW-1:0]      cols,
  input  logic [SW-1:0]      rows,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job,
  output logic [AW-1:0]      job_addr
);

  localparam int IW = 2 * SW + 1;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  // Stage ready chain
  assign r4       = !v4 || job_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Stage 1: offset by the grid origin
  logic signed [32:0] dx_full, dz_full;
  logic               early_out;
  job_t               l1_job;
  logic [AW-1:0]      l1_addr;
  logic [31:0]        l1_dx, l1_dz;

  assign dx_full   = 33'(in_word.pos_x) - 33'(origin_x);
  assign dz_full   = 33'(in_word.pos_z) - 33'(origin_z);
  assign early_out = (dx_full <= 33'sd0) || (dz_full <= 33'sd0) ||
                     (inverse_cell_width == 32'd0) || (inverse_cell_depth == 32'd0);

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      l1_job.is_query <= (in_word.kind == KIND_QUERY);
      l1_job.store    <= (32'(in_word.vertex_index) < 32'(MAX_VERTICES));
      l1_job.outside  <= early_out;
      l1_job.fx       <= '0;
      l1_job.fy       <= '0;
      l1_job.wdata    <= in_word.height_value;
      l1_addr         <= AW'(in_word.vertex_index);
      l1_dx           <= dx_full[31:0];
      l1_dz           <= dz_full[31:0];
    end
  end

  // Stage 2: scale to grid space, Q32.32
  job_t          l2_job;
  logic [AW-1:0] l2_addr;
  logic [63:0]   l2_px, l2_pz;

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      l2_job  <= l1_job;
      l2_addr <= l1_addr;
      l2_px   <= 64'(l1_dx) * 64'(inverse_cell_width);
      l2_pz   <= 64'(l1_dz) * 64'(inverse_cell_depth);
    end
  end

  // Stage 3: interior test, cell and fractions
  logic [31:0]   qx_hi, qz_hi;
  logic          beyond;
  job_t          l3_job_next;
  job_t          l3_job;
  logic [AW-1:0] l3_addr;
  logic [SW-1:0] l3_cx, l3_row;

  assign qx_hi  = l2_px[63:32];
  assign qz_hi  = l2_pz[63:32];
  assign beyond = (qx_hi >= 32'(cols) - 32'd1) || (qz_hi >= 32'(rows) - 32'd1);

  always_comb begin
    l3_job_next         = l2_job;
    l3_job_next.outside = l2_job.outside || beyond;
    l3_job_next.fx      = l2_px[31:16];
    l3_job_next.fy      = 17'h10000 - 17'(l2_pz[31:16]);
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      l3_job          <= l3_job_next;
      l3_addr         <= l2_addr;
      l3_cx           <= SW'(qx_hi);
      // rows counted from the far edge
      l3_row          <= rows - SW'(2) - SW'(qz_hi);
    end
  end

  // Stage 4: far-left corner address for a query, wraps on the store depth; a write keeps its index
  logic [IW-1:0] idx_full;
  job_t          l4_job;
  logic [AW-1:0] l4_addr;

  assign idx_full = IW'(l3_row) * IW'(cols) + IW'(l3_cx);

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      l4_job  <= l3_job;
      l4_addr <= l3_job.is_query ? AW'(idx_full) : l3_addr;
    end
  end

  assign job_valid = v4;
  assign job       = l4_job;
  assign job_addr  = l4_addr;

endmodule

@@ rtl/core/hhq_fetch.sv @@
`timescale 1ns / 1ps

module hhq_fetch
  import hhq_pkg::*;
#(
  parameter int MAX_VERTICES = 65536,
  parameter int AW           = 16,
  parameter int SW           = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  input  logic [AW-1:0] job_addr,
  input  logic [SW-1:0] cols,
  output logic          cor_valid,
  input  logic          cor_ready,
  output corner_set_t   cor
);

  logic [31:0]        mem [MAX_VERTICES];
  logic [31:0]        rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;

  fetch_state_t       state, state_next;
  logic [AW-1:0]      base;
  logic [AW-1:0]      addr_offset;
  logic               advance;
  corner_t            issue_corner;
  logic               rd_valid;
  corner_t            rd_corner;
  logic [15:0]        cur_fx;
  logic [16:0]        cur_fy;
  logic signed [31:0] s0, s1, s2;

  logic               slot_ok;
  logic               accept;
  logic               start;
  logic               load_inside, load_outside;

  assign slot_ok      = !cor_valid || cor_ready;
  assign accept       = job_valid && job_ready;
  assign start        = accept && job.is_query && !job.outside;
  assign mem_we       = accept && !job.is_query && job.store;
  assign load_inside  = rd_valid && (rd_corner == CORNER_NEAR_RIGHT);
  assign load_outside = accept && job.is_query && job.outside;

  // Single port: store on accept, corner reads from the sequencer
  assign mem_addr = (state == FETCH_IDLE) ? job_addr : base + addr_offset;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= job.wdata;
    rd_data <= mem[mem_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FETCH_IDLE:       if (start) state_next = FETCH_FAR_RIGHT;
      FETCH_FAR_RIGHT:  state_next = FETCH_NEAR_LEFT;
      FETCH_NEAR_LEFT:  state_next = FETCH_NEAR_RIGHT;
      FETCH_NEAR_RIGHT: if (slot_ok) state_next = FETCH_IDLE;
      default:          state_next = FETCH_IDLE;
    endcase
  end

  // Outputs; the last read waits until the corner slot can take the set
  always_comb begin
    job_ready    = 1'b0;
    addr_offset  = '0;
    advance      = 1'b0;
    issue_corner = CORNER_FAR_LEFT;
    unique case (state)
      FETCH_IDLE: begin
        // an outside query goes straight to the slot, behind any set in flight
        job_ready = (job.is_query && job.outside) ? (slot_ok && !rd_valid) : 1'b1;
      end
      FETCH_FAR_RIGHT: begin
        addr_offset  = AW'(1);
        advance      = 1'b1;
        issue_corner = CORNER_FAR_RIGHT;
      end
      FETCH_NEAR_LEFT: begin
        addr_offset  = AW'(cols);
        advance      = 1'b1;
        issue_corner = CORNER_NEAR_LEFT;
      end
      FETCH_NEAR_RIGHT: begin
        addr_offset  = AW'(cols) + AW'(1);
        advance      = slot_ok;
        issue_corner = CORNER_NEAR_RIGHT;
      end
      default: begin
        job_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FETCH_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= start || advance;
    end
  end

  // Sequencer payload
  always_ff @(posedge clk) begin
    rd_corner <= issue_corner;
    if (start) begin
      base   <= job_addr;
      cur_fx <= job.fx;
      cur_fy <= job.fy;
    end
  end

  // Corner capture
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      unique case (rd_corner)
        CORNER_FAR_LEFT:   s0 <= rd_data;
        CORNER_FAR_RIGHT:  s1 <= rd_data;
        CORNER_NEAR_LEFT:  s2 <= rd_data;
        CORNER_NEAR_RIGHT: ;
        default:           ;
      endcase
    end
  end

  // Corner slot
  always_ff @(posedge clk) begin
    if (rst) begin
      cor_valid <= 1'b0;
    end else if (load_inside || load_outside) begin
      cor_valid <= 1'b1;
    end else if (cor_ready) begin
      cor_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_inside) begin
      cor.outside <= 1'b0;
      cor.fx      <= cur_fx;
      cor.fy      <= cur_fy;
      cor.y0      <= s0;
      cor.y1      <= s1;
      cor.y2      <= s2;
      cor.y3      <= rd_data;
    end else if (load_outside) begin
      cor.outside <= 1'b1;
      cor.fx      <= job.fx;
      cor.fy      <= job.fy;
    end
  end

endmodule

@@ rtl/core/hhq_blend.sv @@
`timescale 1ns / 1ps

module hhq_blend
  import hhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cor_valid,
  output logic        cor_ready,
  input  corner_set_t cor,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  assign r3        = !v3 || out_ready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign cor_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= cor_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // Stage 1: pick the triangle and its edge differences
  logic               upper;
  logic signed [32:0] da_next, db_next;
  logic signed [31:0] b1_y0;
  logic signed [32:0] b1_da, b1_db;
  logic [15:0]        b1_fx;
  logic [16:0]        b1_fy;
  logic               b1_out;

  assign upper   = 17'(cor.fx) >= cor.fy;
  assign da_next = upper ? 33'(cor.y1) - 33'(cor.y0) : 33'(cor.y3) - 33'(cor.y2);
  assign db_next = upper ? 33'(cor.y3) - 33'(cor.y1) : 33'(cor.y2) - 33'(cor.y0);

  always_ff @(posedge clk) begin
    if (r1 && cor_valid) begin
      b1_y0  <= cor.y0;
      b1_da  <= da_next;
      b1_db  <= db_next;
      b1_fx  <= cor.fx;
      b1_fy  <= cor.fy;
      b1_out <= cor.outside;
    end
  end

  // Stage 2: weight the differences
  logic signed [31:0] b2_y0;
  logic signed [49:0] b2_p1;
  logic signed [50:0] b2_p2;
  logic               b2_out;

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      b2_y0  <= b1_y0;
      b2_p1  <= 50'(b1_da) * $signed({34'h0, b1_fx});
      b2_p2  <= 51'(b1_db) * $signed({34'h0, b1_fy});
      b2_out <= b1_out;
    end
  end

  // Stage 3: sum in Q.16, round half up, saturate
  logic signed [52:0] y0_sh;
  logic signed [52:0] sum;
  logic signed [36:0] h_wide;
  logic signed [31:0] h_sat;

  assign y0_sh  = $signed({{5{b2_y0[31]}}, b2_y0, 16'h0000});
  assign sum    = y0_sh + 53'(b2_p1) + 53'(b2_p2) + 53'sd32768;
  assign h_wide = sum[52:16];

  always_comb begin
    if (h_wide[36:31] == 6'b000000 || h_wide[36:31] == 6'b111111) begin
      h_sat = h_wide[31:0];
    end else if (h_wide[36]) begin
      h_sat = 32'sh8000_0000;
    end else begin
      h_sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      out_word.height  <= b2_out ? 32'sd0 : h_sat;
      out_word.outside <= b2_out;
    end
  end

  assign out_valid = v3;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hhq_pkg::*;

  localparam int MAX_VERTICES = 65536;
  localparam int MAX_SIDE = 256;
  localparam int SETTLE_CYCLES = 16;   // longer than the deepest word in flight
  localparam int DRAIN_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam longint HEIGHT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;

  localparam out_word_t OFF_GRID = '{height: 32'sd0, outside: 1'b1};
  localparam out_word_t ROUND_UP_ONE = '{height: 32'sd1, outside: 1'b0};
  localparam out_word_t ROUND_UP_ZERO = '{height: 32'sd0, outside: 1'b0};

  typedef struct {
    in_word_t  word;
    bit        has_want;
    out_word_t want;
  } stim_row_t;

  typedef struct {
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [31:0] ox;
    logic [31:0] oz;
    logic [31:0] iw;
    logic [31:0] id;
    int          words;
  } grid_setup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our copy of the grid registers and the height store
  logic [8:0] grid_columns = 9'd2;
  logic [8:0] grid_rows = 9'd2;
  logic signed [31:0] origin_x = 32'sd0;
  logic signed [31:0] origin_z = 32'sd0;
  logic [31:0] inv_width = 32'h0001_0000;
  logic [31:0] inv_depth = 32'h0001_0000;
  logic signed [31:0] vertex_heights [MAX_VERTICES];
  bit vertex_set [MAX_VERTICES];

  out_word_t expected_heights [$];
  stim_row_t directed_rows [$];
  grid_setup_t setups [$];
  int faults = 0;
  bit send_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit hold_results = 1'b0;

  heightfield_height_query #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Grid size as the block sees it
  function automatic int side_of(logic [8:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  // Finds the cell under a world position; 0 when off the interior
  function automatic bit locate_cell(input logic signed [31:0] px, input logic signed [31:0] pz,
                                     output int base, output logic [15:0] fx,
                                     output logic [16:0] fy);
    longint dx, dz;
    logic [95:0] gx, gz;
    int cols, rws;
    cols = side_of(grid_columns);
    rws = side_of(grid_rows);
    dx = longint'(px) - longint'(origin_x);
    dz = longint'(pz) - longint'(origin_z);
    base = 0;
    fx = '0;
    fy = '0;
    if (dx <= 0 || dz <= 0 || inv_width == 0 || inv_depth == 0) return 1'b0;
    gx = (96'(dx) * 96'(inv_width)) >> 16;
    gz = (96'(dz) * 96'(inv_depth)) >> 16;
    if (gx >= (96'(cols - 1) << 16) || gz >= (96'(rws - 1) << 16)) return 1'b0;
    fx = gx[15:0];
    fy = 17'h1_0000 - {1'b0, gz[15:0]};
    // rows are counted from the far edge
    base = (rws - 2 - int'(gz[47:16])) * cols + int'(gx[47:16]);
    return 1'b1;
  endfunction

  // Triangle interpolation over the cell, rounded half up and saturated
  function automatic out_word_t predict_height(logic signed [31:0] px, logic signed [31:0] pz);
    out_word_t r;
    int base, cols;
    logic [15:0] fx;
    logic [16:0] fy;
    longint y0, y1, y2, y3, acc, h;
    r = OFF_GRID;
    if (!locate_cell(px, pz, base, fx, fy)) return r;
    cols = side_of(grid_columns);
    y0 = vertex_heights[base % MAX_VERTICES];
    y1 = vertex_heights[(base + 1) % MAX_VERTICES];
    y2 = vertex_heights[(base + cols) % MAX_VERTICES];
    y3 = vertex_heights[(base + cols + 1) % MAX_VERTICES];
    acc = y0 * 65536;
    if (fx >= fy) acc += (y1 - y0) * longint'(fx) + (y3 - y1) * longint'(fy);
    else acc += (y3 - y2) * longint'(fx) + (y2 - y0) * longint'(fy);
    h = (acc + 32768) >>> 16;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    if (h < HEIGHT_MIN) h = HEIGHT_MIN;
    r.height = h[31:0];
    r.outside = 1'b0;
    return r;
  endfunction

  function automatic in_word_t write_word(logic [15:0] idx, logic [31:0] value);
    in_word_t w;
    w.kind = KIND_WRITE;
    w.vertex_index = idx;
    w.height_value = value;
    w.pos_x = $urandom;
    w.pos_z = $urandom;
    return w;
  endfunction

  function automatic in_word_t query_word(logic [31:0] px, logic [31:0] pz);
    in_word_t w;
    w.kind = KIND_QUERY;
    w.vertex_index = 16'($urandom);
    w.height_value = $urandom;
    w.pos_x = px;
    w.pos_z = pz;
    return w;
  endfunction

  // World position along one axis that lands in (or just past) a chosen cell
  function automatic logic [31:0] aim_axis(logic [31:0] org, logic [31:0] inv, int cells);
    logic [63:0] g, d;
    logic [15:0] frac;
    int cell_pick;
    case ($urandom_range(0, 5))
      0: frac = 16'h0000;
      1: frac = 16'hFFFF;
      default: frac = 16'($urandom);
    endcase
    cell_pick = ($urandom_range(0, 7) == 0) ? cells : $urandom_range(0, cells - 1);
    if (inv == 0) return $urandom;
    g = {32'd0, 16'(cell_pick), frac};
    d = (g << 16) / {32'd0, inv};
    d = d + 64'($urandom_range(0, 4)) - 64'd2;
    return org + d[31:0];
  endfunction

  function automatic void add_row(in_word_t w, bit has_want, out_word_t want);
    stim_row_t r;
    r.word = w;
    r.has_want = has_want;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_setup(logic [8:0] cols, logic [8:0] rows, logic [31:0] ox,
                                    logic [31:0] oz, logic [31:0] iw, logic [31:0] id,
                                    int words);
    grid_setup_t g;
    g.cols = cols;
    g.rows = rows;
    g.ox = ox;
    g.oz = oz;
    g.iw = iw;
    g.id = id;
    g.words = words;
    setups.push_back(g);
  endfunction

  // Offer one word; on acceptance update the store or queue the expected height
  task automatic send_word(in_word_t w, int gap, bit has_want, out_word_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.kind == KIND_WRITE) begin
      vertex_heights[w.vertex_index] = w.height_value;
      vertex_set[w.vertex_index] = 1'b1;
    end else begin
      expected_heights.push_back(has_want ? want : predict_height(w.pos_x, w.pos_z));
    end
  endtask

  task automatic offer(in_word_t w);
    if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
    send_word(w, send_calm ? 0 : $urandom_range(0, 18), 1'b0, OFF_GRID);
  endtask

  // Stop offering, let every expected height come back, then let writes settle
  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (expected_heights.size() != 0 && n < DRAIN_LIMIT);
    if (expected_heights.size() != 0) begin
      $display("%0t: %0d heights never arrived, first expected height=%h outside=%b",
               $time, expected_heights.size(), expected_heights[0].height,
               expected_heights[0].outside);
      faults++;
      expected_heights.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg_write_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    case (r)
      REG_COLUMNS: grid_columns = d[8:0];
      REG_ROWS: grid_rows = d[8:0];
      REG_ORIGIN_X: origin_x = d;
      REG_ORIGIN_Z: origin_z = d;
      REG_INV_CELL_WIDTH: inv_width = d;
      REG_INV_CELL_DEPTH: inv_depth = d;
      default: ;
    endcase
  endtask

  // Only called while idle; size registers carry junk above bit 8
  task automatic program_grid(grid_setup_t g);
    write_reg(REG_COLUMNS, {23'($urandom), g.cols});
    write_reg(REG_ROWS, {23'($urandom), g.rows});
    write_reg(REG_ORIGIN_X, g.ox);
    write_reg(REG_ORIGIN_Z, g.oz);
    write_reg(REG_INV_CELL_WIDTH, g.iw);
    write_reg(REG_INV_CELL_DEPTH, g.id);
    cfg_write_en <= 1'b0;
  endtask

  // One random step: a write, or a query preceded by writes to any unset corner
  task automatic issue_random(output int sent);
    int pick, cols, rws, base;
    int corner [4];
    logic [15:0] fx;
    logic [16:0] fy;
    logic [31:0] px, pz;
    cols = side_of(grid_columns);
    rws = side_of(grid_rows);
    sent = 0;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      offer(write_word(16'($urandom_range(0, cols * rws - 1)), $urandom));
      sent = 1;
    end else if (pick == 2) begin
      offer(write_word(16'($urandom), $urandom));
      sent = 1;
    end else begin
      if (pick == 3) begin
        px = $urandom;
        pz = $urandom;
      end else begin
        px = aim_axis(origin_x, inv_width, cols - 1);
        pz = aim_axis(origin_z, inv_depth, rws - 1);
      end
      if (locate_cell(px, pz, base, fx, fy)) begin
        corner = '{base, base + 1, base + cols, base + cols + 1};
        foreach (corner[k]) begin
          if (!vertex_set[corner[k] % MAX_VERTICES]) begin
            offer(write_word(16'(corner[k] % MAX_VERTICES), $urandom));
            sent++;
          end
        end
      end
      offer(query_word(px, pz));
      sent++;
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_word_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = sink_calm ? 0 : $urandom_range(0, 18);
      end
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_heights.size() == 0) begin
        $display("%0t: unexpected word, expected none, got height=%h outside=%b",
                 $time, out_word.height, out_word.outside);
        faults++;
      end else begin
        want = expected_heights.pop_front();
        if (out_word.height !== want.height) begin
          $display("%0t: height expected %h got %h", $time, want.height, out_word.height);
          faults++;
        end
        if (out_word.outside !== want.outside) begin
          $display("%0t: outside expected %b got %b", $time, want.outside, out_word.outside);
          faults++;
        end
      end
    end
  end

  initial begin : stimulus
    int n, sent;
    bit pressed;
    // Directed words, default 2x2 grid of unit cells at the origin
    add_row(write_word(16'd0, 32'h7FFF_FFFF), 1'b0, OFF_GRID);
    add_row(write_word(16'd1, 32'h8000_0000), 1'b0, OFF_GRID);
    add_row(write_word(16'd2, 32'h0000_0000), 1'b0, OFF_GRID);
    add_row(write_word(16'd3, 32'h0001_0000), 1'b0, OFF_GRID);
    add_row(write_word(16'hFFFF, 32'h1234_5678), 1'b0, OFF_GRID);
    // on the origin, far positive, far negative, on each upper bound
    add_row(query_word(32'h0000_0000, 32'h0000_0000), 1'b1, OFF_GRID);
    add_row(query_word(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1, OFF_GRID);
    add_row(query_word(32'h8000_0000, 32'h8000_0000), 1'b1, OFF_GRID);
    add_row(query_word(32'h0001_0000, 32'h0000_8000), 1'b1, OFF_GRID);
    add_row(query_word(32'h0000_8000, 32'h0001_0000), 1'b1, OFF_GRID);
    add_row(query_word(32'h0000_8000, 32'h8000_0000), 1'b1, OFF_GRID);
    // both triangles, the diagonal, the inner corners
    add_row(query_word(32'h0000_0001, 32'h0000_0001), 1'b0, OFF_GRID);
    add_row(query_word(32'h0000_FFFF, 32'h0000_FFFF), 1'b0, OFF_GRID);
    add_row(query_word(32'h0000_8000, 32'h0000_8000), 1'b0, OFF_GRID);
    add_row(query_word(32'h0000_4000, 32'h0000_C000), 1'b0, OFF_GRID);
    // exact half-LSB ties round towards plus infinity
    add_row(write_word(16'd0, 32'h0000_0000), 1'b0, OFF_GRID);
    add_row(write_word(16'd1, 32'h0000_0001), 1'b0, OFF_GRID);
    add_row(write_word(16'd3, 32'h0000_0001), 1'b0, OFF_GRID);
    add_row(query_word(32'h0000_8000, 32'h0000_FFFF), 1'b1, ROUND_UP_ONE);
    add_row(write_word(16'd1, 32'hFFFF_FFFF), 1'b0, OFF_GRID);
    add_row(write_word(16'd3, 32'hFFFF_FFFF), 1'b0, OFF_GRID);
    add_row(query_word(32'h0000_8000, 32'h0000_FFFF), 1'b1, ROUND_UP_ZERO);

    // Grid settings: defaults, extremes, clamped sizes, zero scales, then random
    add_setup(9'd2, 9'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 60);
    add_setup(9'd5, 9'd3, 32'hFFFD_0000, 32'h0012_0000, 32'h0000_8000, 32'h0002_0000, 100);
    add_setup(9'd256, 9'd256, 32'h8000_0000, 32'h8000_0000, 32'h0000_0100, 32'h0000_0100, 90);
    add_setup(9'd0, 9'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30);
    add_setup(9'd511, 9'd300, 32'hFFFF_FFFB, 32'h0000_0007, 32'hFFFF_FFFF, 32'h0000_0001, 60);
    add_setup(9'd4, 9'd6, $urandom, $urandom, 32'h0, 32'h0001_0000, 20);
    add_setup(9'd6, 9'd4, $urandom, $urandom, 32'h0001_0000, 32'h0, 20);
    repeat (7) begin
      add_setup(9'($urandom_range(2, 12)), 9'($urandom_range(2, 12)),
                $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000,
                $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000,
                $urandom_range(32'h4000, 32'h8_0000), $urandom_range(32'h4000, 32'h8_0000),
                110);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, $urandom_range(0, 18), directed_rows[i].has_want,
                directed_rows[i].want);
    end

    foreach (setups[s]) begin
      wait_idle();
      program_grid(setups[s]);
      pressed = 1'b0;
      n = 0;
      while (n < setups[s].words) begin
        // halfway: either back-pressure from the sink or a full drain
        if (!pressed && n >= setups[s].words / 2) begin
          pressed = 1'b1;
          if (s % 2) begin
            hold_results = 1'b1;
            send_calm = 1'b1;
          end else begin
            wait_idle();
          end
        end
        issue_random(sent);
        n += sent;
      end
    end

    wait_idle();
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
